/* design/midi_track_event_parser_top_assert.svh */
// Assertion macros for the checker file of the track event parser.
// Expects clk_i and rst_ni to be visible where a macro is used.
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MTEP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("parser assertion failed");

// Next-cycle implication, disabled during reset.
`define MTEP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("parser assertion failed");

`endif

/* design/mtep_pkg.sv */
// Types and constants for the MIDI track event parser.
// No dependencies; used by the parser, the top level and the checker.
package mtep_pkg;

  localparam int unsigned VLQ_MAX_BYTES_DEF = 4;

  typedef enum logic [3:0] {
    KIND_NOTE_OFF   = 4'd0,
    KIND_NOTE_ON    = 4'd1,
    KIND_CONTROLLER = 4'd2,
    KIND_PROGRAM    = 4'd3,
    KIND_CHAN_PRESS = 4'd4,
    KIND_POLY_PRESS = 4'd5,
    KIND_PITCH_BEND = 4'd6,
    KIND_META       = 4'd7,
    KIND_SYSEX      = 4'd8,
    KIND_PAYLOAD    = 4'd9,
    KIND_ERROR      = 4'd10
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NO_STATUS  = 2'd0,
    ERR_BAD_STATUS = 2'd1,
    ERR_BAD_DATA   = 2'd2,
    ERR_VLQ_LONG   = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    PH_DELTA      = 4'd0,
    PH_STATUS     = 4'd1,
    PH_DATA1      = 4'd2,
    PH_DATA2      = 4'd3,
    PH_META_TYPE  = 4'd4,
    PH_META_LEN   = 4'd5,
    PH_META_DATA  = 4'd6,
    PH_SYSEX_LEN  = 4'd7,
    PH_SYSEX_DATA = 4'd8,
    PH_DONE       = 4'd9
  } phase_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       track_start;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  channel;
    logic [31:0] tick;
    logic [6:0]  data_a;
    logic [14:0] event_value;
    logic [7:0]  meta_kind;
    logic [27:0] payload_length;
    logic [7:0]  payload_byte;
    logic        end_of_track;
    err_e        error_code;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

/* design/mtep_parser.sv */
// Parser state and per-byte decode of the MIDI track event parser.
// Depends on mtep_pkg; the result is registered by the top level.
module mtep_parser #(
  parameter int unsigned VLQ_MAX_BYTES = mtep_pkg::VLQ_MAX_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  mtep_pkg::in_item_t item_i,
  output mtep_pkg::result_t  res_o
);

  localparam logic [2:0] VlqMax     = 3'(VLQ_MAX_BYTES);
  localparam logic [3:0] TypNoteOff = 4'h8;
  localparam logic [3:0] TypNoteOn  = 4'h9;
  localparam logic [3:0] TypPoly    = 4'hA;
  localparam logic [3:0] TypCtrl    = 4'hB;
  localparam logic [3:0] TypProgram = 4'hC;
  localparam logic [3:0] TypChPress = 4'hD;
  localparam logic [3:0] TypBend    = 4'hE;
  localparam logic [7:0] StMeta     = 8'hFF;
  localparam logic [7:0] StSysex    = 8'hF0;
  localparam logic [7:0] StSysexEnd = 8'hF7;
  localparam logic [7:0] MetaEot    = 8'h2F;

  mtep_pkg::phase_e phase_q, phase_d, ph;
  logic [8:0]  run_q, run_d, bak_q, bak_d;
  logic [31:0] tick_q, tick_d;
  logic [27:0] acc_q, acc_d;
  logic [2:0]  nb_q, nb_d;
  logic [7:0]  held_q, held_d;
  logic [6:0]  first_q, first_d;
  logic [7:0]  meta_q, meta_d;
  logic [27:0] left_q, left_d, total_q, total_d;
  logic        lock_q, lock_d;

  // Effective state once a track start on this beat has been applied.
  logic        ts, lock;
  logic [8:0]  rs, bs;
  logic [31:0] tk;
  logic [27:0] acc;
  logic [2:0]  nb;

  logic [7:0]  b;
  logic [27:0] acc_new, left_new;
  logic [2:0]  nb_new;
  logic        vlq_done, vlq_over, no_status, clamp, left_zero, eot;
  logic [7:0]  eff_status, hs;
  logic [3:0]  typ;
  logic [6:0]  sec7;

  assign ts   = item_i.track_start;
  assign b    = item_i.stream_byte;
  assign ph   = ts ? mtep_pkg::PH_DELTA : phase_q;
  assign lock = ts ? 1'b0 : lock_q;
  assign rs   = ts ? 9'd0 : run_q;
  assign bs   = ts ? 9'd0 : bak_q;
  assign tk   = ts ? 32'd0 : tick_q;
  assign acc  = ts ? 28'd0 : acc_q;
  assign nb   = ts ? 3'd0 : nb_q;

  assign acc_new  = {acc[20:0], b[6:0]};
  assign nb_new   = nb + 3'd1;
  assign vlq_done = !b[7];
  assign vlq_over = b[7] && (nb_new >= VlqMax);

  assign no_status  = !rs[8] && !bs[8];
  assign eff_status = rs[8] ? rs[7:0] : bs[7:0];
  assign hs         = (ph == mtep_pkg::PH_STATUS) ? eff_status : held_q;
  assign typ        = hs[7:4];
  assign sec7       = b[7] ? 7'h7F : b[6:0];
  assign clamp      = (typ == TypNoteOff) || (typ == TypNoteOn) || (typ == TypPoly) ||
                      ((typ == TypCtrl) &&
                       ((first_q == 7'd7) || (first_q == 7'd11) || (first_q == 7'd93)));
  assign left_new   = left_q - 28'd1;
  assign left_zero  = (left_new == 28'd0);
  assign eot        = (meta_q == MetaEot);

  // Next state.
  always_comb begin
    phase_d = ph;
    run_d   = rs;
    bak_d   = bs;
    tick_d  = tk;
    acc_d   = acc;
    nb_d    = nb;
    held_d  = held_q;
    first_d = first_q;
    meta_d  = meta_q;
    left_d  = left_q;
    total_d = total_q;
    lock_d  = lock;
    if (!lock) begin
      case (ph)
        mtep_pkg::PH_DELTA: begin
          acc_d = acc_new;
          nb_d  = nb_new;
          if (vlq_over) begin
            lock_d = 1'b1;
          end else if (vlq_done) begin
            tick_d  = tk + {4'd0, acc_new};
            phase_d = mtep_pkg::PH_STATUS;
          end
        end
        mtep_pkg::PH_STATUS, mtep_pkg::PH_DATA1: begin
          if (!b[7] && ((ph == mtep_pkg::PH_DATA1) || !no_status)) begin
            if (ph == mtep_pkg::PH_STATUS) begin
              if (!rs[8]) begin
                run_d = bs;
              end
              held_d = eff_status;
            end
            first_d = b[6:0];
            if ((typ == TypProgram) || (typ == TypChPress)) begin
              phase_d = mtep_pkg::PH_DELTA;
              acc_d   = 28'd0;
              nb_d    = 3'd0;
            end else begin
              phase_d = mtep_pkg::PH_DATA2;
            end
          end else if (ph == mtep_pkg::PH_DATA1 || !b[7]) begin
            lock_d = 1'b1;
          end else if (b < StSysex) begin
            run_d   = {1'b1, b};
            bak_d   = {1'b1, b};
            held_d  = b;
            phase_d = mtep_pkg::PH_DATA1;
          end else if (b == StMeta) begin
            run_d   = 9'd0;
            phase_d = mtep_pkg::PH_META_TYPE;
          end else if (b inside {StSysex, StSysexEnd}) begin
            run_d   = 9'd0;
            acc_d   = 28'd0;
            nb_d    = 3'd0;
            phase_d = mtep_pkg::PH_SYSEX_LEN;
          end else begin
            lock_d = 1'b1;
          end
        end
        mtep_pkg::PH_DATA2: begin
          if (b[7] && !clamp) begin
            lock_d = 1'b1;
          end else begin
            phase_d = mtep_pkg::PH_DELTA;
            acc_d   = 28'd0;
            nb_d    = 3'd0;
            if (!(typ inside {TypNoteOff, TypNoteOn, TypPoly, TypCtrl, TypBend})) begin
              lock_d = 1'b1;
            end
          end
        end
        mtep_pkg::PH_META_TYPE: begin
          meta_d  = b;
          acc_d   = 28'd0;
          nb_d    = 3'd0;
          phase_d = mtep_pkg::PH_META_LEN;
        end
        mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
          acc_d = acc_new;
          nb_d  = nb_new;
          if (vlq_over) begin
            lock_d = 1'b1;
          end else if (vlq_done) begin
            total_d = acc_new;
            left_d  = acc_new;
            if (acc_new == 28'd0) begin
              acc_d = 28'd0;
              nb_d  = 3'd0;
              if ((ph == mtep_pkg::PH_META_LEN) && eot) begin
                phase_d = mtep_pkg::PH_DONE;
              end else begin
                phase_d = mtep_pkg::PH_DELTA;
              end
            end else if (ph == mtep_pkg::PH_META_LEN) begin
              phase_d = mtep_pkg::PH_META_DATA;
            end else begin
              phase_d = mtep_pkg::PH_SYSEX_DATA;
            end
          end
        end
        mtep_pkg::PH_META_DATA, mtep_pkg::PH_SYSEX_DATA: begin
          left_d = left_new;
          if (left_zero) begin
            acc_d = 28'd0;
            nb_d  = 3'd0;
            if ((ph == mtep_pkg::PH_META_DATA) && eot) begin
              phase_d = mtep_pkg::PH_DONE;
            end else begin
              phase_d = mtep_pkg::PH_DELTA;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result of this beat, if any.
  always_comb begin
    res_o       = '0;
    res_o.item.tick = tick_d;
    if (!lock) begin
      case (ph)
        mtep_pkg::PH_DELTA: begin
          if (vlq_over) begin
            res_o.valid           = 1'b1;
            res_o.item.kind       = mtep_pkg::KIND_ERROR;
            res_o.item.error_code = mtep_pkg::ERR_VLQ_LONG;
          end
        end
        mtep_pkg::PH_STATUS, mtep_pkg::PH_DATA1: begin
          if (!b[7] && (ph == mtep_pkg::PH_STATUS) && no_status) begin
            res_o.valid           = 1'b1;
            res_o.item.kind       = mtep_pkg::KIND_ERROR;
            res_o.item.error_code = mtep_pkg::ERR_NO_STATUS;
          end else if (!b[7]) begin
            if (typ == TypProgram) begin
              res_o.valid        = 1'b1;
              res_o.item.kind    = mtep_pkg::KIND_PROGRAM;
              res_o.item.channel = hs[3:0];
              res_o.item.data_a  = b[6:0];
            end else if (typ == TypChPress) begin
              res_o.valid            = 1'b1;
              res_o.item.kind        = mtep_pkg::KIND_CHAN_PRESS;
              res_o.item.channel     = hs[3:0];
              res_o.item.event_value = {8'd0, b[6:0]};
            end
          end else if (ph == mtep_pkg::PH_DATA1) begin
            res_o.valid           = 1'b1;
            res_o.item.kind       = mtep_pkg::KIND_ERROR;
            res_o.item.error_code = mtep_pkg::ERR_BAD_DATA;
          end else if (!((b < StSysex) || (b == StMeta) || (b == StSysex) ||
                         (b == StSysexEnd))) begin
            res_o.valid           = 1'b1;
            res_o.item.kind       = mtep_pkg::KIND_ERROR;
            res_o.item.error_code = mtep_pkg::ERR_BAD_STATUS;
          end
        end
        mtep_pkg::PH_DATA2: begin
          res_o.valid            = 1'b1;
          res_o.item.channel     = hs[3:0];
          res_o.item.data_a      = first_q;
          res_o.item.event_value = {8'd0, sec7};
          if (b[7] && !clamp) begin
            res_o.item             = '0;
            res_o.item.tick        = tick_d;
            res_o.item.kind        = mtep_pkg::KIND_ERROR;
            res_o.item.error_code  = mtep_pkg::ERR_BAD_DATA;
          end else begin
            case (typ)
              TypNoteOff: res_o.item.kind = mtep_pkg::KIND_NOTE_OFF;
              TypNoteOn:  res_o.item.kind = mtep_pkg::KIND_NOTE_ON;
              TypBend:    res_o.item.kind = mtep_pkg::KIND_PITCH_BEND;
              TypCtrl:    res_o.item.kind = mtep_pkg::KIND_CONTROLLER;
              TypPoly: begin
                res_o.item.kind        = mtep_pkg::KIND_POLY_PRESS;
                res_o.item.event_value = {first_q, 1'b0, sec7};
              end
              default: begin
                res_o.item            = '0;
                res_o.item.tick       = tick_d;
                res_o.item.kind       = mtep_pkg::KIND_ERROR;
                res_o.item.error_code = mtep_pkg::ERR_BAD_STATUS;
              end
            endcase
          end
        end
        mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
          if (vlq_over) begin
            res_o.valid           = 1'b1;
            res_o.item.kind       = mtep_pkg::KIND_ERROR;
            res_o.item.error_code = mtep_pkg::ERR_VLQ_LONG;
          end else if (vlq_done && (acc_new == 28'd0)) begin
            // An empty payload closes the event on its last length byte.
            res_o.valid = 1'b1;
            if (ph == mtep_pkg::PH_META_LEN) begin
              res_o.item.kind         = mtep_pkg::KIND_META;
              res_o.item.meta_kind    = meta_q;
              res_o.item.end_of_track = eot;
            end else begin
              res_o.item.kind = mtep_pkg::KIND_SYSEX;
            end
          end
        end
        mtep_pkg::PH_META_DATA, mtep_pkg::PH_SYSEX_DATA: begin
          res_o.valid             = 1'b1;
          res_o.item.payload_byte = b;
          if (!left_zero) begin
            res_o.item.kind = mtep_pkg::KIND_PAYLOAD;
          end else if (ph == mtep_pkg::PH_META_DATA) begin
            res_o.item.kind           = mtep_pkg::KIND_META;
            res_o.item.meta_kind      = meta_q;
            res_o.item.payload_length = total_q;
            res_o.item.end_of_track   = eot;
          end else begin
            // A closing F7 is not counted in the sysex length.
            res_o.item.kind           = mtep_pkg::KIND_SYSEX;
            res_o.item.payload_length = (b == StSysexEnd) ? total_q - 28'd1 : total_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mtep_pkg::PH_DELTA;
      run_q   <= '0;
      bak_q   <= '0;
      tick_q  <= '0;
      acc_q   <= '0;
      nb_q    <= '0;
      held_q  <= '0;
      first_q <= '0;
      meta_q  <= '0;
      left_q  <= '0;
      total_q <= '0;
      lock_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      run_q   <= run_d;
      bak_q   <= bak_d;
      tick_q  <= tick_d;
      acc_q   <= acc_d;
      nb_q    <= nb_d;
      held_q  <= held_d;
      first_q <= first_d;
      meta_q  <= meta_d;
      left_q  <= left_d;
      total_q <= total_d;
      lock_q  <= lock_d;
    end
  end

endmodule

/* design/midi_track_event_parser_top.sv */
// A result beat is registered and offered in the cycle after its input beat is taken.
// Throughput: one input beat per cycle; a held result stalls input only while not taken.
// The parser state and the output register form the single stage.
// Reset (asynchronous, active low) returns the parser to delta time with no status,
// zero ticks and no lock, and empties the output register.
module midi_track_event_parser_top #(
  parameter int unsigned VLQ_MAX_BYTES = mtep_pkg::VLQ_MAX_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mtep_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mtep_pkg::out_item_t out_data_o
);

  mtep_pkg::result_t   res;
  mtep_pkg::out_item_t out_data_q;
  logic                out_valid_q;
  logic                take;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  mtep_parser #(
    .VLQ_MAX_BYTES(VLQ_MAX_BYTES)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (take),
    .item_i (in_data_i),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= res.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res.valid) begin
      out_data_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* design/mtep_checker.sv */
// Port-level checks for the MIDI track event parser, bound to its top level.
// Depends on mtep_pkg and midi_track_event_parser_top_assert.svh.
`include "midi_track_event_parser_top_assert.svh"

module mtep_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input mtep_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mtep_pkg::out_item_t out_data_o
);

  // An input beat that is not taken stays offered and unchanged.
  `MTEP_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(in_data_i))

  // A result beat that is not taken stays offered and unchanged.
  `MTEP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // With the output register empty the parser always takes a beat.
  `MTEP_ASSERT_NOW(a_ready_empty, !out_valid_o, in_ready_o)

  // Error records carry only the code and the tick.
  `MTEP_ASSERT_NOW(a_err_clean, out_valid_o && (out_data_o.kind == mtep_pkg::KIND_ERROR),
                   (out_data_o.channel == 4'd0) && (out_data_o.payload_length == 28'd0) &&
                   (out_data_o.event_value == 15'd0) && !out_data_o.end_of_track)

  // End of track is flagged by meta records alone.
  `MTEP_ASSERT_NOW(a_eot_meta, out_valid_o && out_data_o.end_of_track,
                   (out_data_o.kind == mtep_pkg::KIND_META) && (out_data_o.meta_kind == 8'h2F))

endmodule

bind midi_track_event_parser_top mtep_checker u_checker (.*);
